FILE: rtl/cmca_pkg.sv
// Package: shared types, codes and sizes of the collision map conflict analyzer.
`default_nettype none
package cmca_pkg;

    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLUMNS = 64;
    localparam int ROW_W           = 64;
    localparam int CFG_W           = 7;
    localparam int OUT_W           = 48;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SETUP,
        ST_PROBE,
        ST_CHECK,
        ST_CINIT,
        ST_CSUM,
        ST_CDRAIN,
        ST_RESULT
    } cmca_state_t;

    typedef enum logic [1:0] {
        SPH_MID,
        SPH_UP,
        SPH_DN
    } srch_phase_t;

    typedef enum logic [1:0] {
        BLK_FIRST     = 2'd0,
        BLK_SECOND    = 2'd1,
        BLK_UNDECIDED = 2'd2
    } blk_choice_t;

    typedef struct packed {
        logic accept;
        logic setup;
        logic col_init;
        logic issue;
        logic advance;
        logic capture;
        logic sweep;
        logic result;
    } cmca_cmd_t;

    typedef struct packed {
        logic last_row;
        logic row_any;
        logic col_any;
        logic col_side;
        logic cand_ok;
        logic hit;
        logic sweep_last;
        logic out_free;
    } cmca_sts_t;

endpackage
`default_nettype wire

FILE: rtl/cmca_ctrl.sv
// Controller: sequences loading, centre searches, column sweep and result hand-off.
`default_nettype none
module cmca_ctrl
    import cmca_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire cmca_sts_t sts,
    output cmca_cmd_t      cmd
);

    cmca_state_t state_reg;
    cmca_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid && sts.last_row)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = sts.row_any ? ST_PROBE : ST_CINIT;
            end
            ST_PROBE:
            begin
                if (sts.cand_ok)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.hit)
                begin
                    state_next = ST_PROBE;
                end
                else if (sts.col_side)
                begin
                    state_next = ST_CSUM;
                end
                else
                begin
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT:
            begin
                state_next = sts.col_any ? ST_PROBE : ST_RESULT;
            end
            ST_CSUM:
            begin
                if (sts.sweep_last)
                begin
                    state_next = ST_CDRAIN;
                end
            end
            ST_CDRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_PROBE:
            begin
                cmd.issue   = sts.cand_ok;
                cmd.advance = !sts.cand_ok;
            end
            ST_CHECK:
            begin
                cmd.capture = sts.hit;
                cmd.advance = !sts.hit;
            end
            ST_CINIT:
            begin
                cmd.col_init = 1'b1;
            end
            ST_CSUM:
            begin
                cmd.sweep = 1'b1;
            end
            ST_CDRAIN:
            begin
                cmd = '0;
            end
            ST_RESULT:
            begin
                cmd.result = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/cmca_dp.sv
// Datapath: row store, running map statistics, centre search unit and result register.
`default_nettype none
module cmca_dp
    import cmca_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic [ROW_W-1:0] row_bits,
    input  wire logic             last_row,
    input  wire cmca_cmd_t        cmd,
    output cmca_sts_t             sts,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [OUT_W-1:0]      out_data
);

    localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW  = AW + 1;
    localparam int SIW  = ((AW > 6) ? AW : 6) + 2;
    localparam int SUMW = (RCW > 7) ? RCW : 7;

    logic [ROW_W-1:0] map_mem [MAX_ROWS];
    logic [6:0]       cnt_mem [MAX_ROWS];
    logic [ROW_W-1:0] map_rd_reg;
    logic [6:0]       cnt_rd_reg;
    logic             colbit_reg;

    logic [CFG_W-1:0] cols_reg;
    logic [RCW-1:0]   row_cnt_reg;
    logic [ROW_W-1:0] any_col_reg;
    logic             diag_reg;
    logic             ext_row_reg;
    logic             ext_col_reg;
    logic             v0_reg;
    logic             vlast_reg;
    logic [SIW-1:0]   lead2_reg;
    logic [SIW-1:0]   lead1_reg;
    logic             rf_in_v_reg;
    logic [AW-1:0]    rf_in_reg;
    logic [AW-1:0]    rl_in_reg;
    logic             rf_ex_v_reg;
    logic [AW-1:0]    rf_ex_reg;
    logic [AW-1:0]    rl_ex_reg;

    logic [SIW-1:0]   s_first_reg;
    logic [SIW-1:0]   s_last_reg;
    logic [SIW-1:0]   s_mid_reg;
    logic [SIW-1:0]   s_d_reg;
    srch_phase_t      s_phase_reg;
    logic             col_side_reg;

    logic [5:0]       cr_reg;
    logic [6:0]       crc_reg;
    logic [5:0]       cc_reg;
    logic [SUMW-1:0]  sum_reg;
    logic [AW-1:0]    sweep_reg;
    logic             rdv_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic [6:0]       nc_eff;
    logic [6:0]       ncm1;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] mrow;
    logic [ROW_W-1:0] gtm;
    logic [ROW_W-1:0] newb;
    logic [ROW_W-1:0] colv;
    logic [SIW-1:0]   i_ext;
    logic [SIW-1:0]   nr_ext;
    logic             store_en;
    logic             nz;
    logic             dbit;
    logic             ext_row_now;
    logic             ext_col_now;
    logic [5:0]       lo;
    logic [5:0]       hb;
    logic [5:0]       cf;
    logic [5:0]       cl;
    logic [6:0]       pc;
    logic [SIW-1:0]   lo_ext;
    logic [SIW-1:0]   hb_ext;
    logic [SIW-1:0]   cand;
    logic             cand_ok;
    logic             hit;
    logic [SIW-1:0]   r_mid;
    logic [SIW-1:0]   c_mid;
    logic             diag_f;
    logic             v2;
    logic             v3;
    logic             p1;
    logic             p2;
    blk_choice_t      choice;
    logic [SIW-1:0]   nc_ext;

    always_comb
    begin
        if (cols_reg == '0)
        begin
            nc_eff = 7'd1;
        end
        else if (cols_reg > 7'(MAX_COLUMNS))
        begin
            nc_eff = 7'(MAX_COLUMNS);
        end
        else
        begin
            nc_eff = cols_reg;
        end
    end

    assign ncm1     = nc_eff - 7'd1;
    assign nc_ext   = SIW'(nc_eff);
    assign nr_ext   = SIW'(row_cnt_reg);
    assign i_ext    = SIW'(row_cnt_reg[AW-1:0]);
    assign store_en = cmd.accept && (row_cnt_reg < RCW'(MAX_ROWS));

    always_comb
    begin
        for (int j = 0; j < ROW_W; j++)
        begin
            mask[j] = (7'(j) < nc_eff);
            gtm[j]  = (SIW'(j) > i_ext);
            colv[j] = any_col_reg[j] && (j != 0) && ((7'(j) + 7'd2) <= nc_eff);
        end
    end

    assign mrow        = row_bits & mask;
    assign newb        = mrow & ~any_col_reg;
    assign nz          = |mrow;
    assign dbit        = (i_ext < SIW'(ROW_W)) && mrow[i_ext[5:0]];
    assign ext_row_now = |(mrow & gtm);
    assign ext_col_now = (i_ext >= nc_ext) && mrow[ncm1[5:0]];

    always_comb
    begin
        lo = '0;
        cf = '0;
        for (int j = ROW_W - 1; j >= 0; j--)
        begin
            if (mrow[j])
            begin
                lo = 6'(j);
            end
            if (colv[j])
            begin
                cf = 6'(j);
            end
        end
    end

    always_comb
    begin
        hb = '0;
        cl = '0;
        pc = '0;
        for (int j = 0; j < ROW_W; j++)
        begin
            if (newb[j])
            begin
                hb = 6'(j);
            end
            if (colv[j])
            begin
                cl = 6'(j);
            end
            pc = pc + 7'(mrow[j]);
        end
    end

    assign lo_ext = SIW'(lo);
    assign hb_ext = SIW'(hb);

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            map_mem[row_cnt_reg[AW-1:0]] <= mrow;
            cnt_mem[row_cnt_reg[AW-1:0]] <= pc;
        end
        if (cmd.issue)
        begin
            cnt_rd_reg <= cnt_mem[cand[AW-1:0]];
            colbit_reg <= colv[cand[5:0]];
        end
        if (cmd.sweep)
        begin
            map_rd_reg <= map_mem[sweep_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            cols_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            any_col_reg <= '0;
            diag_reg    <= 1'b0;
            ext_row_reg <= 1'b0;
            ext_col_reg <= 1'b0;
            v0_reg      <= 1'b0;
            vlast_reg   <= 1'b0;
            lead2_reg   <= '0;
            lead1_reg   <= '0;
            rf_in_v_reg <= 1'b0;
            rf_in_reg   <= '0;
            rl_in_reg   <= '0;
            rf_ex_v_reg <= 1'b0;
            rf_ex_reg   <= '0;
            rl_ex_reg   <= '0;
        end
        else if (cmd.result)
        begin
            row_cnt_reg <= '0;
            any_col_reg <= '0;
            diag_reg    <= 1'b0;
            ext_row_reg <= 1'b0;
            ext_col_reg <= 1'b0;
            lead2_reg   <= '0;
            lead1_reg   <= '0;
            rf_in_v_reg <= 1'b0;
            rf_ex_v_reg <= 1'b0;
        end
        else if (store_en)
        begin
            row_cnt_reg <= row_cnt_reg + RCW'(1);
            any_col_reg <= any_col_reg | mrow;
            diag_reg    <= diag_reg | dbit;
            ext_row_reg <= ext_row_now;
            ext_col_reg <= ext_col_reg | ext_col_now;
            vlast_reg   <= nz;
            if (i_ext == '0)
            begin
                v0_reg <= nz;
            end
            if (nz && (i_ext > lo_ext) && ((i_ext - lo_ext) > lead2_reg))
            begin
                lead2_reg <= i_ext - lo_ext;
            end
            if ((|newb) && (hb_ext > i_ext) && ((hb_ext - i_ext) > lead1_reg))
            begin
                lead1_reg <= hb_ext - i_ext;
            end
            rf_ex_v_reg <= rf_in_v_reg;
            rf_ex_reg   <= rf_in_reg;
            rl_ex_reg   <= rl_in_reg;
            if ((i_ext != '0) && nz)
            begin
                if (!rf_in_v_reg)
                begin
                    rf_in_v_reg <= 1'b1;
                    rf_in_reg   <= row_cnt_reg[AW-1:0];
                end
                rl_in_reg <= row_cnt_reg[AW-1:0];
            end
        end
    end

    assign r_mid = SIW'(rf_ex_reg) + ((SIW'(rl_ex_reg) - SIW'(rf_ex_reg)) >> 1);
    assign c_mid = SIW'(cf) + ((SIW'(cl) - SIW'(cf)) >> 1);

    always_comb
    begin
        case (s_phase_reg)
            SPH_MID:
            begin
                cand    = s_mid_reg;
                cand_ok = 1'b1;
            end
            SPH_UP:
            begin
                cand    = s_mid_reg + s_d_reg;
                cand_ok = (s_mid_reg + s_d_reg) <= s_last_reg;
            end
            SPH_DN:
            begin
                cand    = s_mid_reg - s_d_reg;
                cand_ok = s_mid_reg >= (s_first_reg + s_d_reg);
            end
            default:
            begin
                cand    = s_mid_reg;
                cand_ok = 1'b0;
            end
        endcase
    end

    assign hit = col_side_reg ? colbit_reg : (cnt_rd_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_phase_reg  <= SPH_MID;
            col_side_reg <= 1'b0;
            rdv_reg      <= 1'b0;
        end
        else
        begin
            rdv_reg <= cmd.sweep;
            if (cmd.setup)
            begin
                s_phase_reg  <= SPH_MID;
                col_side_reg <= 1'b0;
            end
            else if (cmd.col_init)
            begin
                s_phase_reg  <= SPH_MID;
                col_side_reg <= 1'b1;
            end
            else if (cmd.advance)
            begin
                case (s_phase_reg)
                    SPH_MID:
                    begin
                        s_phase_reg <= SPH_UP;
                    end
                    SPH_UP:
                    begin
                        s_phase_reg <= SPH_DN;
                    end
                    SPH_DN:
                    begin
                        s_phase_reg <= SPH_UP;
                    end
                    default:
                    begin
                        s_phase_reg <= SPH_MID;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            s_first_reg <= SIW'(rf_ex_reg);
            s_last_reg  <= SIW'(rl_ex_reg);
            s_mid_reg   <= r_mid;
            s_d_reg     <= '0;
            cr_reg      <= nr_ext[6:1];
            crc_reg     <= '0;
        end
        else if (cmd.col_init)
        begin
            s_first_reg <= SIW'(cf);
            s_last_reg  <= SIW'(cl);
            s_mid_reg   <= c_mid;
            s_d_reg     <= '0;
            cc_reg      <= nc_eff[6:1];
            sum_reg     <= '0;
        end
        else if (cmd.advance)
        begin
            if (s_phase_reg != SPH_UP)
            begin
                s_d_reg <= s_d_reg + SIW'(1);
            end
        end
        else if (cmd.capture)
        begin
            if (col_side_reg)
            begin
                cc_reg    <= cand[5:0];
                sweep_reg <= '0;
            end
            else
            begin
                cr_reg  <= cand[5:0];
                crc_reg <= cnt_rd_reg;
            end
        end
        if (cmd.sweep)
        begin
            sweep_reg <= sweep_reg + AW'(1);
        end
        if (rdv_reg)
        begin
            sum_reg <= sum_reg + SUMW'(map_rd_reg[cc_reg]);
        end
    end

    assign diag_f = diag_reg | ((nr_ext <= nc_ext) ? ext_row_reg : ext_col_reg);
    assign v2     = any_col_reg[0];
    assign v3     = any_col_reg[ncm1[5:0]];
    assign p1     = !vlast_reg && !v2;
    assign p2     = !v0_reg && !v3;

    always_comb
    begin
        if (v2 && v3 && !(v0_reg && vlast_reg))
        begin
            choice = BLK_FIRST;
        end
        else if (v0_reg && vlast_reg && !(v2 && v3))
        begin
            choice = BLK_SECOND;
        end
        else
        begin
            choice = BLK_UNDECIDED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            out_data_reg <= {lead1_reg[5:0], lead2_reg[5:0], sum_reg[6:0], cc_reg,
                             crc_reg, cr_reg, choice, v3, v2, vlast_reg, v0_reg,
                             p2, p1, !p1 && !p2, diag_f};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sts.last_row   = last_row;
    assign sts.row_any    = rf_ex_v_reg;
    assign sts.col_any    = |colv;
    assign sts.col_side   = col_side_reg;
    assign sts.cand_ok    = cand_ok;
    assign sts.hit        = hit;
    assign sts.sweep_last = (RCW'(sweep_reg) == (row_cnt_reg - RCW'(1)));
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

FILE: rtl/collision_map_conflict_analyzer.sv
// Top level: collision map conflict analyzer.
// Usage:
//   s_tdata carries one 64-bit map row per item; s_tlast marks the final row.
//   Rows load one per cycle while in load mode; only the low columns_used bits
//   count, and rows beyond MAX_ROWS are dropped (the final flag still counts).
//   cfg_we/cfg_data write columns_used while the block is idle.
// Analysis:
//   After the final row the block leaves load mode and analyzes the map:
//   a row centre search that reads the row count store per probe, a column
//   centre search that tests the column occupancy per probe, then a sweep of
//   the row store to count the centre column. The row search is skipped when
//   no row qualifies, and the column search and sweep when no column does.
//   Rows of the next map are accepted once the result is handed to the output
//   register; one result item per map appears on m_tdata.
// Reset: all control state clears, columns_used returns to 64, load mode.
// Stall: a result waits in the output register; the block holds in its final
//   analysis step until that register frees.
`default_nettype none
module collision_map_conflict_analyzer
    import cmca_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data,   // columns_used
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [ROW_W-1:0] s_tdata,    // row_bits
    input  wire logic             s_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata     // diagonal_hit, deadlock, first_arm_priority,
                                              // second_arm_priority, corner_flags[3:0],
                                              // blocking_choice[1:0], centre_row[5:0],
                                              // centre_row_count[6:0], centre_column[5:0],
                                              // centre_column_count[6:0],
                                              // second_arm_lead[5:0], first_arm_lead[5:0]
);

    cmca_cmd_t cmd;
    cmca_sts_t sts;

    cmca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cmca_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .row_bits  (s_tdata),
        .last_row  (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_leave_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("load mode kept after final row");

    a_choice_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:8] != 2'b11))
        else $error("blocking choice code out of range");

    a_deadlock: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1] == !(m_tdata[2] || m_tdata[3])))
        else $error("deadlock disagrees with priority flags");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |=> m_tvalid)
        else $error("result not presented");

endmodule
`default_nettype wire
